FILE: hw/rtl/serial_loaded_bank_mapper_top_macros.svh
// Assertion macros for the serial-loaded bank mapper.
// Included by the top level; the including module must provide clk and rst.
`ifndef SERIAL_LOADED_BANK_MAPPER_TOP_MACROS_SVH
`define SERIAL_LOADED_BANK_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slbm assertion failed");

// Next-cycle implication, disabled during reset.
`define SLBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slbm assertion failed");

`endif

FILE: hw/rtl/slbm_pkg.sv
// Shared types and constants for the serial-loaded bank mapper.
// No dependencies; used by slbm_ctrl, slbm_dp and the top level.
`default_nettype none

package slbm_pkg;

  localparam int unsigned PRG_BANKS_MAX = 32;
  localparam int unsigned CHR_UNITS_MAX = 16;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned MAP_W  = 19;
  localparam int unsigned CFG_W  = 6;

  // Access kinds
  localparam logic [1:0] KIND_CPU_RD = 2'd0;
  localparam logic [1:0] KIND_CPU_WR = 2'd1;
  localparam logic [1:0] KIND_PPU_RD = 2'd2;

  // Result targets
  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_PRG_RD  = 3'd1;
  localparam logic [2:0] TGT_RAM_RD  = 3'd2;
  localparam logic [2:0] TGT_RAM_WR  = 3'd3;
  localparam logic [2:0] TGT_CHR_RD  = 3'd4;
  localparam logic [2:0] TGT_REG_WR  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_UNITS = 2'd0;
  localparam logic [1:0] CFG_CHR_UNITS = 2'd1;
  localparam logic [1:0] CFG_RAM       = 2'd2;

  // Reset values
  localparam logic [5:0] PRG_UNITS_RST = 6'd2;
  localparam logic [4:0] CHR_UNITS_RST = 5'd1;
  localparam logic [4:0] SHIFT_RST     = 5'h10;
  localparam logic [4:0] CONTROL_RST   = 5'h0C;

  typedef struct packed {
    logic load;   // capture a beat, run serial write, set up the divider
    logic step;   // one restoring-division step
    logic form;   // build the result into the output register
  } cmd_t;

  typedef struct packed {
    logic div_last;  // divider is on its final step
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/serial_loaded_bank_mapper_top.sv
// Serial-loaded bank mapper: top level joining sequencer and datapath.
// Each request is loaded, takes five divide steps, then one form step that sets rsp_valid.
// req_stall is high until the beat is formed; the bank modulo divider is 1-bit-per-cycle.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst, synchronous, active high) restores config and mapper registers at once.
`default_nettype none

`include "serial_loaded_bank_mapper_top_macros.svh"

module serial_loaded_bank_mapper_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    kind,
  input  logic [slbm_pkg::ADDR_W-1:0]   address,
  input  logic [7:0]                    value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [2:0]                    target,
  output logic [slbm_pkg::MAP_W-1:0]    mapped_address,
  output logic [1:0]                    mirroring,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [slbm_pkg::CFG_W-1:0]    cfg_data
);
  import slbm_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;
  logic  tgt_unmapped;
  logic  tgt_ram;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  slbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  slbm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .address        (address),
    .value          (value),
    .target         (target),
    .mapped_address (mapped_address),
    .mirroring      (mirroring)
  );

  assign tgt_unmapped = (target == TGT_NONE) || (target == TGT_REG_WR);
  assign tgt_ram      = (target == TGT_RAM_RD) || (target == TGT_RAM_WR);

  `SLBM_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  `SLBM_ASSERT_NOW(a_unmapped_zero, rsp_valid && tgt_unmapped, mapped_address == '0)
  `SLBM_ASSERT_NOW(a_ram_in_window, rsp_valid && tgt_ram, mapped_address[MAP_W-1:13] == '0)

endmodule

`default_nettype wire

FILE: hw/rtl/slbm_ctrl.sv
// Sequencer for the bank mapper: load, five divide steps, result formation.
// Depends on slbm_pkg (cmd_t, stat_t).
`default_nettype none

module slbm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  input  slbm_pkg::stat_t stat,
  output slbm_pkg::cmd_t  cmd
);
  import slbm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FORM
  } state_t;

  state_t state;
  logic   out_free;

  always_comb begin
    out_free  = !rsp_valid || !rsp_stall;
    req_stall = (state != ST_IDLE);
    cmd.load  = (state == ST_IDLE) && req_valid;
    cmd.step  = (state == ST_DIV);
    cmd.form  = (state == ST_FORM) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.form) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) state <= ST_DIV;
        end
        ST_DIV: begin
          if (stat.div_last) state <= ST_FORM;
        end
        ST_FORM: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/slbm_dp.sv
// Datapath for the bank mapper: mapper registers, config, bank divider, result regs.
// Depends on slbm_pkg (constants, cmd_t, stat_t).
`default_nettype none

module slbm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  slbm_pkg::cmd_t                cmd,
  output slbm_pkg::stat_t               stat,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [slbm_pkg::CFG_W-1:0]    cfg_data,
  input  logic [1:0]                    kind,
  input  logic [slbm_pkg::ADDR_W-1:0]   address,
  input  logic [7:0]                    value,
  output logic [2:0]                    target,
  output logic [slbm_pkg::MAP_W-1:0]    mapped_address,
  output logic [1:0]                    mirroring
);
  import slbm_pkg::*;

  // configuration
  logic [5:0] prg_units_cfg;
  logic [4:0] chr_units_cfg;
  logic       ram_cfg;

  // mapper state
  logic [4:0] shift_reg;
  logic [4:0] control_reg;
  logic [4:0] chr_bank_lo;
  logic [4:0] chr_bank_hi;
  logic [4:0] prg_bank_reg;

  // per-beat working registers
  logic [ADDR_W-1:0] addr_q;
  logic [2:0]        tgt_q;
  logic [4:0]        num_q;
  logic [5:0]        div_d;
  logic [4:0]        rem_q;
  logic [2:0]        cnt_q;

  logic [5:0]       prg_units;
  logic [4:0]       chr_units;
  logic [5:0]       chr_n;
  logic             ram_on;
  logic             ram_window;
  logic [2:0]       tgt_next;
  logic [4:0]       num_next;
  logic [5:0]       d_next;
  logic [4:0]       shift_next;
  logic [5:0]       trial;
  logic [4:0]       rem_next;
  logic [4:0]       units_m1;
  logic [4:0]       prg_bank;
  logic [14:0]      prg_off;
  logic [MAP_W-1:0] prg_map;
  logic [MAP_W-1:0] chr_map;
  logic [MAP_W-1:0] ram_map;
  logic [MAP_W-1:0] map_next;

  always_comb begin
    if (prg_units_cfg == 6'd0) begin
      prg_units = 6'd1;
    end else if (prg_units_cfg > 6'(PRG_BANKS_MAX)) begin
      prg_units = 6'(PRG_BANKS_MAX);
    end else begin
      prg_units = prg_units_cfg;
    end
    if (chr_units_cfg == 5'd0) begin
      chr_units = 5'd1;
    end else if (chr_units_cfg > 5'(CHR_UNITS_MAX)) begin
      chr_units = 5'(CHR_UNITS_MAX);
    end else begin
      chr_units = chr_units_cfg;
    end
    chr_n    = {chr_units, 1'b0};   // count of 4 KiB banks
    units_m1 = 5'(prg_units - 6'd1);

    ram_on     = ram_cfg && !prg_bank_reg[4];
    ram_window = !address[15] && address[14] && address[13];  // 0x6000-0x7FFF

    case (kind)
      KIND_CPU_RD: tgt_next = address[15] ? TGT_PRG_RD :
                              (ram_window && ram_on) ? TGT_RAM_RD : TGT_NONE;
      KIND_CPU_WR: tgt_next = address[15] ? TGT_REG_WR :
                              (ram_window && ram_on) ? TGT_RAM_WR : TGT_NONE;
      KIND_PPU_RD: tgt_next = (address[15:13] == 3'd0) ? TGT_CHR_RD : TGT_NONE;
      default:     tgt_next = TGT_NONE;
    endcase

    if (kind == KIND_PPU_RD) begin
      d_next = chr_n;
      if (control_reg[4]) begin
        num_next = address[12] ? chr_bank_hi : chr_bank_lo;
      end else begin
        num_next = chr_bank_lo & 5'h1E;
      end
    end else begin
      d_next   = prg_units;
      num_next = control_reg[3] ? (prg_bank_reg & 5'h0F) : (prg_bank_reg & 5'h0E);
    end

    shift_next = {value[0], shift_reg[4:1]};

    // restoring division, one numerator bit per step
    trial    = {rem_q, num_q[4]};
    rem_next = (trial >= div_d) ? 5'(trial - div_d) : trial[4:0];
    stat.div_last = (cnt_q == 3'd4);

    case (control_reg[3:2])
      2'b10:   prg_bank = addr_q[14] ? rem_q : 5'd0;
      2'b11:   prg_bank = addr_q[14] ? units_m1 : rem_q;
      default: prg_bank = rem_q;
    endcase
    prg_off = control_reg[3] ? {1'b0, addr_q[13:0]} : addr_q[14:0];
    prg_map = {prg_bank, 14'd0} + {4'd0, prg_off};

    if (control_reg[4]) begin
      chr_map = {2'd0, rem_q, addr_q[11:0]};
    end else begin
      chr_map = {2'd0, rem_q, 12'd0} + {6'd0, addr_q[12:0]};
    end
    ram_map = {6'd0, addr_q[12:0]};

    case (tgt_q) inside
      TGT_PRG_RD:             map_next = prg_map;
      TGT_RAM_RD, TGT_RAM_WR: map_next = ram_map;
      TGT_CHR_RD:             map_next = chr_map;
      default:                map_next = '0;
    endcase
  end

  // configuration and mapper registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_units_cfg <= PRG_UNITS_RST;
      chr_units_cfg <= CHR_UNITS_RST;
      ram_cfg       <= 1'b0;
      shift_reg     <= SHIFT_RST;
      control_reg   <= CONTROL_RST;
      chr_bank_lo   <= 5'd0;
      chr_bank_hi   <= 5'd0;
      prg_bank_reg  <= 5'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PRG_UNITS: prg_units_cfg <= cfg_data;
          CFG_CHR_UNITS: chr_units_cfg <= cfg_data[4:0];
          CFG_RAM:       ram_cfg       <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load && kind == KIND_CPU_WR && address[15]) begin
        if (value[7]) begin
          shift_reg <= SHIFT_RST;
        end else if (shift_reg[0]) begin
          // marker bit reached the bottom: fifth bit is in
          shift_reg <= SHIFT_RST;
          unique case (address[14:13] & 2'b00 | address[13:12])
            2'd0:    control_reg  <= shift_next;
            2'd1:    chr_bank_lo  <= shift_next;
            2'd2:    chr_bank_hi  <= shift_next;
            default: prg_bank_reg <= shift_next;
          endcase
        end else begin
          shift_reg <= shift_next;
        end
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q <= address;
      tgt_q  <= tgt_next;
      num_q  <= num_next;
      div_d  <= d_next;
      rem_q  <= 5'd0;
      cnt_q  <= 3'd0;
    end else if (cmd.step) begin
      num_q <= {num_q[3:0], 1'b0};
      rem_q <= rem_next;
      cnt_q <= cnt_q + 3'd1;
    end
    if (cmd.form) begin
      target         <= tgt_q;
      mapped_address <= map_next;
      mirroring      <= control_reg[1:0];
    end
  end

endmodule

`default_nettype wire
